### rtl/core/obb_ovl_pkg.sv
package obb_ovl_pkg;

   // Field widths of one box pair
   localparam int COORD_W           = 32;
   localparam int HALF_W            = 31;
   localparam int AXIS_W            = 16;
   localparam int AXIS_FRAC         = 14;
   localparam int MARGIN_W          = 16;
   localparam int FRAC_BITS_DEFAULT = 16;

   // Derived datapath widths
   localparam int PROD_W    = 2 * AXIS_W;         // axis times axis, Q.28
   localparam int DOT_W     = COORD_W + AXIS_W;   // coordinate times axis, Q.30
   localparam int DOT_MAG_W = DOT_W;              // magnitude of a two-term dot
   localparam int SQ_W      = 2 * COORD_W;        // squared distance terms
   localparam int RSUM_W    = COORD_W + 1;        // sum of both coarse radii

   // Stream widths
   localparam int REQ_DATA_W = 256;
   localparam int RSP_DATA_W = 8;

   // Per-stage load enables, stage 1 nearest the input
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } obb_ovl_en_type;

endpackage

### rtl/core/obb_ovl_rotate.sv
module obb_ovl_rotate
   import obb_ovl_pkg::*;
(
   input  logic                        clock,
   input  obb_ovl_en_type              en,
   input  logic signed [COORD_W-1:0]   offset_x,
   input  logic signed [COORD_W-1:0]   offset_y,
   input  logic        [HALF_W-1:0]    a_half_width,
   input  logic        [HALF_W-1:0]    a_half_height,
   input  logic signed [AXIS_W-1:0]    a_cos,
   input  logic signed [AXIS_W-1:0]    a_sin,
   input  logic        [HALF_W-1:0]    b_half_width,
   input  logic        [HALF_W-1:0]    b_half_height,
   input  logic signed [AXIS_W-1:0]    b_cos,
   input  logic signed [AXIS_W-1:0]    b_sin,
   // stage 2 results: projections of the offset on A x, A y, B x, B y
   output logic [3:0][DOT_MAG_W-1:0]   dot_mag,
   // |cos of angle between boxes| and |sin of angle between boxes|, Q.28
   output logic [PROD_W-1:0]           par_mag,
   output logic [PROD_W-1:0]           crs_mag,
   output logic [HALF_W-1:0]           aw,
   output logic [HALF_W-1:0]           ah,
   output logic [HALF_W-1:0]           bw,
   output logic [HALF_W-1:0]           bh
);

   // Stage 1 products
   logic signed [PROD_W-1:0] bcac_ff, bsas_ff, bsac_ff, bcas_ff;
   logic signed [DOT_W-1:0]  txac_ff, tyas_ff, txas_ff, tyac_ff;
   logic signed [DOT_W-1:0]  txbc_ff, tybs_ff, txbs_ff, tybc_ff;
   logic [HALF_W-1:0]        aw1_ff, ah1_ff, bw1_ff, bh1_ff;

   // Stage 2 sums and magnitudes
   logic signed [PROD_W:0]   par_sum_in, crs_sum_in;
   logic signed [DOT_W:0]    dot_ax_in, dot_ay_in, dot_bx_in, dot_by_in;
   logic [3:0][DOT_MAG_W-1:0] dot_mag_ff;
   logic [PROD_W-1:0]        par_mag_ff, crs_mag_ff;
   logic [HALF_W-1:0]        aw2_ff, ah2_ff, bw2_ff, bh2_ff;

   // Multiply axis components with each other and with the offset
   always_ff @(posedge clock) begin
      if (en.s1) begin
         bcac_ff <= PROD_W'(b_cos) * PROD_W'(a_cos);
         bsas_ff <= PROD_W'(b_sin) * PROD_W'(a_sin);
         bsac_ff <= PROD_W'(b_sin) * PROD_W'(a_cos);
         bcas_ff <= PROD_W'(b_cos) * PROD_W'(a_sin);
         txac_ff <= DOT_W'(offset_x) * DOT_W'(a_cos);
         tyas_ff <= DOT_W'(offset_y) * DOT_W'(a_sin);
         txas_ff <= DOT_W'(offset_x) * DOT_W'(a_sin);
         tyac_ff <= DOT_W'(offset_y) * DOT_W'(a_cos);
         txbc_ff <= DOT_W'(offset_x) * DOT_W'(b_cos);
         tybs_ff <= DOT_W'(offset_y) * DOT_W'(b_sin);
         txbs_ff <= DOT_W'(offset_x) * DOT_W'(b_sin);
         tybc_ff <= DOT_W'(offset_y) * DOT_W'(b_cos);
         aw1_ff  <= a_half_width;
         ah1_ff  <= a_half_height;
         bw1_ff  <= b_half_width;
         bh1_ff  <= b_half_height;
      end
   end

   // Sum the products; B x . A y is minus B y . A x, so two magnitudes cover all four
   assign par_sum_in = (PROD_W+1)'(bcac_ff) + (PROD_W+1)'(bsas_ff);
   assign crs_sum_in = (PROD_W+1)'(bcas_ff) - (PROD_W+1)'(bsac_ff);
   assign dot_ax_in  = (DOT_W+1)'(txac_ff) + (DOT_W+1)'(tyas_ff);
   assign dot_ay_in  = (DOT_W+1)'(tyac_ff) - (DOT_W+1)'(txas_ff);
   assign dot_bx_in  = (DOT_W+1)'(txbc_ff) + (DOT_W+1)'(tybs_ff);
   assign dot_by_in  = (DOT_W+1)'(tybc_ff) - (DOT_W+1)'(txbs_ff);

   // Take magnitudes and hold the half extents alongside
   always_ff @(posedge clock) begin
      if (en.s2) begin
         par_mag_ff    <= par_sum_in[PROD_W] ? PROD_W'(-par_sum_in) : PROD_W'(par_sum_in);
         crs_mag_ff    <= crs_sum_in[PROD_W] ? PROD_W'(-crs_sum_in) : PROD_W'(crs_sum_in);
         dot_mag_ff[0] <= dot_ax_in[DOT_W] ? DOT_MAG_W'(-dot_ax_in) : DOT_MAG_W'(dot_ax_in);
         dot_mag_ff[1] <= dot_ay_in[DOT_W] ? DOT_MAG_W'(-dot_ay_in) : DOT_MAG_W'(dot_ay_in);
         dot_mag_ff[2] <= dot_bx_in[DOT_W] ? DOT_MAG_W'(-dot_bx_in) : DOT_MAG_W'(dot_bx_in);
         dot_mag_ff[3] <= dot_by_in[DOT_W] ? DOT_MAG_W'(-dot_by_in) : DOT_MAG_W'(dot_by_in);
         aw2_ff        <= aw1_ff;
         ah2_ff        <= ah1_ff;
         bw2_ff        <= bw1_ff;
         bh2_ff        <= bh1_ff;
      end
   end

   assign dot_mag = dot_mag_ff;
   assign par_mag = par_mag_ff;
   assign crs_mag = crs_mag_ff;
   assign aw      = aw2_ff;
   assign ah      = ah2_ff;
   assign bw      = bw2_ff;
   assign bh      = bh2_ff;

endmodule

### rtl/core/obb_ovl_coarse.sv
module obb_ovl_coarse
   import obb_ovl_pkg::*;
(
   input  logic                        clock,
   input  obb_ovl_en_type              en,
   input  logic [MARGIN_W-1:0]         margin,
   input  logic signed [COORD_W-1:0]   offset_x,
   input  logic signed [COORD_W-1:0]   offset_y,
   input  logic        [HALF_W-1:0]    a_half_width,
   input  logic        [HALF_W-1:0]    a_half_height,
   input  logic        [HALF_W-1:0]    b_half_width,
   input  logic        [HALF_W-1:0]    b_half_height,
   // stage 4 result
   output logic                        near
);

   logic [SQ_W-2:0]   sqx_ff, sqy_ff;
   logic [HALF_W-1:0] max_a_ff, max_b_ff;
   logic [SQ_W-1:0]   dist2_ff, dist2_3_ff, rad2_ff;
   logic [RSUM_W-1:0] rsum_ff;
   logic              rbig_ff;
   logic              near_ff;

   // Square the offset and pick each box's largest half extent
   always_ff @(posedge clock) begin
      if (en.s1) begin
         sqx_ff   <= (SQ_W-1)'(SQ_W'(offset_x) * SQ_W'(offset_x));
         sqy_ff   <= (SQ_W-1)'(SQ_W'(offset_y) * SQ_W'(offset_y));
         max_a_ff <= (a_half_width > a_half_height) ? a_half_width : a_half_height;
         max_b_ff <= (b_half_width > b_half_height) ? b_half_width : b_half_height;
      end
   end

   // Sum squared distance and both padded radii
   always_ff @(posedge clock) begin
      if (en.s2) begin
         dist2_ff <= SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
         rsum_ff  <= RSUM_W'(max_a_ff) + RSUM_W'(max_b_ff)
                     + RSUM_W'(margin) + RSUM_W'(margin);
      end
   end

   // Square the radius sum; a sum past the coordinate range is always near
   always_ff @(posedge clock) begin
      if (en.s3) begin
         rbig_ff    <= rsum_ff[RSUM_W-1];
         rad2_ff    <= SQ_W'(rsum_ff[RSUM_W-2:0]) * SQ_W'(rsum_ff[RSUM_W-2:0]);
         dist2_3_ff <= dist2_ff;
      end
   end

   // Compare
   always_ff @(posedge clock) begin
      if (en.s4) begin
         near_ff <= rbig_ff || (dist2_3_ff <= rad2_ff);
      end
   end

   assign near = near_ff;

endmodule

### rtl/core/obb_ovl_axis.sv
module obb_ovl_axis
   import obb_ovl_pkg::*;
(
   input  logic                  clock,
   input  obb_ovl_en_type        en,
   input  logic [DOT_MAG_W-1:0]  dot_mag,
   input  logic [HALF_W-1:0]     half,
   input  logic [HALF_W-1:0]     other_h1,
   input  logic [PROD_W-1:0]     other_m1,
   input  logic [HALF_W-1:0]     other_h2,
   input  logic [PROD_W-1:0]     other_m2,
   // stage 4 result
   output logic                  sep
);

   localparam int LHS_W  = DOT_MAG_W + AXIS_FRAC;
   localparam int HSH_W  = HALF_W + 2 * AXIS_FRAC;
   localparam int PRJ_W  = HALF_W + PROD_W;
   localparam int RHS_W  = SQ_W + 1;

   logic [LHS_W-1:0]  lhs_ff;
   logic [HALF_W-1:0] half_ff;
   logic [PRJ_W-1:0]  prj1_ff, prj2_ff;
   logic [RHS_W-1:0]  rhs_in;
   logic              sep_ff;

   // Project the other box's scaled axes onto this axis
   always_ff @(posedge clock) begin
      if (en.s3) begin
         lhs_ff  <= {dot_mag, {AXIS_FRAC{1'b0}}};
         half_ff <= half;
         prj1_ff <= PRJ_W'(other_h1) * PRJ_W'(other_m1);
         prj2_ff <= PRJ_W'(other_h2) * PRJ_W'(other_m2);
      end
   end

   // Separated when the offset projection exceeds the sum of both radii, all in Q.44
   assign rhs_in = RHS_W'({half_ff, {(2 * AXIS_FRAC){1'b0}}})
                   + RHS_W'(prj1_ff) + RHS_W'(prj2_ff);

   always_ff @(posedge clock) begin
      if (en.s4) begin
         sep_ff <= RHS_W'(lhs_ff) > rhs_in;
      end
   end

   assign sep = sep_ff;

   // Unused upper bits of the shifted half extent stay within the compare width
   localparam int HSH_CHECK = (HSH_W < RHS_W) ? 1 : 0;
   initial_width_ok : assert property (@(posedge clock) HSH_CHECK == 1)
      else $error("half extent shift wider than compare");

endmodule

### rtl/core/obb_pair_overlap_test.sv
// Pair test for two 2D oriented boxes by the separating axis theorem.
// req channel: one box pair per transfer. tdata carries offsets, half extents and
// orientation of both boxes; tuser carries the trigger flag. rsp channel: one
// result per pair with near, collide and restore_position, in arrival order.
// csr channel: write of the near margin (Q0.16), always ready; write it only
// while no pair is in flight.
// The accepting edge loads the first of four compute stages; the output register
// follows them and drives rsp. Throughput: one pair per cycle while rsp is not
// stalled, set by the four-stage pipeline whose deepest stages hold 32x32
// multipliers (squared distance, radius square) and 31x32 multipliers (axis
// projections).
// Reset clears all valid bits and loads the margin with 0.05 in the chosen
// fixed point format. When rsp_tready is low the result holds; each stage
// holds only if it is full and the stage after it holds, so bubbles close up
// and req_tready falls only once all five registers are full.
module obb_pair_overlap_test
   import obb_ovl_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // offset_x[31:0], offset_y[63:32], a_half_width[94:64], a_half_height[125:95],
   // a_cos[141:126], a_sin[157:142], b_half_width[188:158], b_half_height[219:189],
   // b_cos[235:220], b_sin[251:236], zero [255:252]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // either_trigger[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // near[0], collide[1], restore_position[2], zero [7:3]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [MARGIN_W-1:0]    csr_data
);

   localparam longint MARGIN_RAW   = ((longint'(5) << FRAC_BITS) + 50) / 100;
   localparam longint MARGIN_MAX   = (longint'(1) << MARGIN_W) - 1;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET =
      MARGIN_W'((MARGIN_RAW > MARGIN_MAX) ? MARGIN_MAX : MARGIN_RAW);

   // Unpacked request fields
   logic signed [COORD_W-1:0] offset_x, offset_y;
   logic        [HALF_W-1:0]  a_half_width, a_half_height, b_half_width, b_half_height;
   logic signed [AXIS_W-1:0]  a_cos, a_sin, b_cos, b_sin;

   obb_ovl_en_type           en;
   logic                     out_en;
   logic [3:0]               stage_valid_ff;
   logic [3:0]               trig_ff;
   logic [MARGIN_W-1:0]      margin_ff;
   logic                     rsp_valid_ff;
   logic                     near_out_ff, collide_out_ff, restore_out_ff;
   logic                     collide_in;

   logic [3:0][DOT_MAG_W-1:0] dot_mag;
   logic [PROD_W-1:0]         par_mag, crs_mag;
   logic [HALF_W-1:0]         aw, ah, bw, bh;
   logic                      near;
   logic [3:0]                sep;

   assign offset_x      = req_tdata[31:0];
   assign offset_y      = req_tdata[63:32];
   assign a_half_width  = req_tdata[94:64];
   assign a_half_height = req_tdata[125:95];
   assign a_cos         = req_tdata[141:126];
   assign a_sin         = req_tdata[157:142];
   assign b_half_width  = req_tdata[188:158];
   assign b_half_height = req_tdata[219:189];
   assign b_cos         = req_tdata[235:220];
   assign b_sin         = req_tdata[251:236];

   // Advance each stage when it is empty or the next one advances
   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign en.s4      = !stage_valid_ff[3] || out_en;
   assign en.s3      = !stage_valid_ff[2] || en.s4;
   assign en.s2      = !stage_valid_ff[1] || en.s3;
   assign en.s1      = !stage_valid_ff[0] || en.s2;
   assign req_tready = en.s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (en.s1) stage_valid_ff[0] <= req_tvalid;
         if (en.s2) stage_valid_ff[1] <= stage_valid_ff[0];
         if (en.s3) stage_valid_ff[2] <= stage_valid_ff[1];
         if (en.s4) stage_valid_ff[3] <= stage_valid_ff[2];
         if (out_en) rsp_valid_ff     <= stage_valid_ff[3];
      end
   end

   // Carry the trigger flag beside the data
   always_ff @(posedge clock) begin
      if (en.s1) trig_ff[0] <= req_tuser;
      if (en.s2) trig_ff[1] <= trig_ff[0];
      if (en.s3) trig_ff[2] <= trig_ff[1];
      if (en.s4) trig_ff[3] <= trig_ff[2];
   end

   // Margin register, written on each csr transfer
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else if (csr_valid && csr_ready) begin
         margin_ff <= csr_data;
      end
   end

   obb_ovl_rotate u_rotate (
      .clock         (clock),
      .en            (en),
      .offset_x      (offset_x),
      .offset_y      (offset_y),
      .a_half_width  (a_half_width),
      .a_half_height (a_half_height),
      .a_cos         (a_cos),
      .a_sin         (a_sin),
      .b_half_width  (b_half_width),
      .b_half_height (b_half_height),
      .b_cos         (b_cos),
      .b_sin         (b_sin),
      .dot_mag       (dot_mag),
      .par_mag       (par_mag),
      .crs_mag       (crs_mag),
      .aw            (aw),
      .ah            (ah),
      .bw            (bw),
      .bh            (bh)
   );

   obb_ovl_coarse u_coarse (
      .clock         (clock),
      .en            (en),
      .margin        (margin_ff),
      .offset_x      (offset_x),
      .offset_y      (offset_y),
      .a_half_width  (a_half_width),
      .a_half_height (a_half_height),
      .b_half_width  (b_half_width),
      .b_half_height (b_half_height),
      .near          (near)
   );

   // Axis of A, x
   obb_ovl_axis u_axis_ax (
      .clock (clock), .en (en), .dot_mag (dot_mag[0]), .half (aw),
      .other_h1 (bw), .other_m1 (par_mag), .other_h2 (bh), .other_m2 (crs_mag),
      .sep (sep[0])
   );

   // Axis of A, y
   obb_ovl_axis u_axis_ay (
      .clock (clock), .en (en), .dot_mag (dot_mag[1]), .half (ah),
      .other_h1 (bw), .other_m1 (crs_mag), .other_h2 (bh), .other_m2 (par_mag),
      .sep (sep[1])
   );

   // Axis of B, x
   obb_ovl_axis u_axis_bx (
      .clock (clock), .en (en), .dot_mag (dot_mag[2]), .half (bw),
      .other_h1 (aw), .other_m1 (par_mag), .other_h2 (ah), .other_m2 (crs_mag),
      .sep (sep[2])
   );

   // Axis of B, y
   obb_ovl_axis u_axis_by (
      .clock (clock), .en (en), .dot_mag (dot_mag[3]), .half (bh),
      .other_h1 (aw), .other_m1 (crs_mag), .other_h2 (ah), .other_m2 (par_mag),
      .sep (sep[3])
   );

   // Combine and hold the result until the transfer
   assign collide_in = near && (sep == '0);

   always_ff @(posedge clock) begin
      if (out_en) begin
         near_out_ff    <= near;
         collide_out_ff <= collide_in;
         restore_out_ff <= collide_in && !trig_ff[3];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-3){1'b0}}, restore_out_ff, collide_out_ff, near_out_ff};

   stall_means_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready && (stage_valid_ff == '1)))
      else $error("input stalled with room in the pipeline");

   accept_fills_stage : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> stage_valid_ff[0])
      else $error("accepted pair lost at stage 1");

   collide_needs_near : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> rsp_tdata[0])
      else $error("collide reported on a pair that is not near");

   restore_needs_collide : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2]) |-> rsp_tdata[1])
      else $error("restore reported without collide");

endmodule
